### sv/text_mode_display_controller_assert.svh
// Assertion macros for the checker file.
`ifndef TEXT_MODE_DISPLAY_CONTROLLER_ASSERT_SVH
`define TEXT_MODE_DISPLAY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TMDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmdc check failed");

// Next-cycle implication, off during reset.
`define TMDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmdc check failed");

// Next-cycle implication that stays armed through reset.
`define TMDC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tmdc check failed");

`endif

### sv/tmdc_pkg.sv
package tmdc_pkg;

   localparam int COLS_DEFAULT          = 20;
   localparam int ROWS_DEFAULT          = 8;
   localparam int BOTTOM_LINE_DEFAULT   = 224;
   localparam int SCREEN_WIDTH_DEFAULT  = 320;
   localparam int SCREEN_HEIGHT_DEFAULT = 240;

   localparam int COLOR_W      = 16;
   localparam int CODE_W       = 8;
   localparam int FONT_ADDR_W  = 12;
   localparam int MODE_W       = 3;
   localparam int POS_W        = 8;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
   localparam logic [CODE_W-1:0]  CHAR_CR     = 8'd13;
   localparam logic [CODE_W-1:0]  CHAR_LF     = 8'd10;
   localparam logic [CODE_W-1:0]  CHAR_SPACE  = 8'd32;
   localparam logic [CODE_W-1:0]  HEX_DIGIT_BASE = 8'd48;
   localparam logic [CODE_W-1:0]  HEX_ALPHA_BASE = 8'd55;
   localparam logic [3:0]         HEX_LAST_DIGIT = 4'd9;

   typedef enum logic [MODE_W-1:0] {
      MODE_PRINT    = 3'd0,
      MODE_HEX      = 3'd1,
      MODE_POSITION = 3'd2,
      MODE_CLEAR    = 3'd3,
      MODE_FONT     = 3'd4,
      MODE_PIXEL    = 3'd5
   } mode_type;

   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } ctl_state_type;

   // what the scanner hands to the pixel pipeline for one tick
   typedef struct packed {
      logic       blank;
      logic       first;
      logic       last;
      logic [3:0] glyph_line;
      logic [2:0] bit_sel;
   } scan_info_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

### sv/tmdc_if.sv
interface tmdc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tmdc_pkg::MODE_W-1:0]          mode;
   logic [tmdc_pkg::CODE_W-1:0]          char_code;
   logic [tmdc_pkg::COLOR_W-1:0]         pen_color;
   logic signed [tmdc_pkg::POS_W-1:0]    pos_x;
   logic signed [tmdc_pkg::POS_W-1:0]    pos_y;
   logic [tmdc_pkg::FONT_ADDR_W-1:0]     font_address;
   logic [tmdc_pkg::CODE_W-1:0]          font_byte;

   modport source (
      output valid, mode, char_code, pen_color, pos_x, pos_y, font_address, font_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, char_code, pen_color, pos_x, pos_y, font_address, font_byte,
      output ready
   );
endinterface

interface tmdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tmdc_pkg::COLOR_W-1:0] pixel_color;
   logic                         frame_start;
   logic                         frame_last;

   modport source (
      output valid, pixel_color, frame_start, frame_last,
      input  ready
   );
   modport sink (
      input  valid, pixel_color, frame_start, frame_last,
      output ready
   );
endinterface

interface tmdc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tmdc_pkg::COLOR_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

### sv/tmdc_scan.sv
module tmdc_scan #(
   parameter int COLS          = tmdc_pkg::COLS_DEFAULT,
   parameter int ROWS          = tmdc_pkg::ROWS_DEFAULT,
   parameter int BOTTOM_LINE   = tmdc_pkg::BOTTOM_LINE_DEFAULT,
   parameter int SCREEN_WIDTH  = tmdc_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = tmdc_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   output tmdc_pkg::scan_info_type                       info,
   output logic [tmdc_pkg::addr_width(COLS*ROWS)-1:0]    cell_addr,
   output logic [tmdc_pkg::addr_width(ROWS)-1:0]         row_index
);
   localparam int CB_AW = tmdc_pkg::addr_width(COLS*ROWS);
   localparam int RI_W  = tmdc_pkg::addr_width(ROWS);
   localparam int SW_W  = $clog2(SCREEN_WIDTH);
   localparam int SH_W  = $clog2(SCREEN_HEIGHT);
   localparam int TR_W  = $clog2(ROWS + 1);

   logic [SW_W-1:0] scan_col_ff, scan_col_in;
   logic [SH_W-1:0] scan_line_ff, scan_line_in;
   logic [TR_W-1:0] text_row_ff, text_row_in;
   logic [3:0]      glyph_line_ff, glyph_line_in;

   logic            last_col;
   logic            last_pix;
   logic            blank;
   logic [SH_W:0]   next_line;
   logic            below;
   logic            line_done;
   logic            row_done;

   always_comb begin
      last_col  = 32'(scan_col_ff) >= SCREEN_WIDTH - 1;
      last_pix  = last_col && (32'(scan_line_ff) >= SCREEN_HEIGHT - 1);
      blank     = (32'(scan_col_ff) >= COLS * 16) || (32'(text_row_ff) >= ROWS);
      next_line = {1'b0, scan_line_ff} + 1'b1;
      below     = 32'(next_line) >= BOTTOM_LINE;
      // above the bottom line each glyph line is shown twice, a row is 32 lines
      line_done = !next_line[0] || below;
      row_done  = (next_line[4:0] == 5'd0) || ((next_line[3:0] == 4'd0) && below);

      info.blank      = blank;
      info.first      = (scan_col_ff == '0) && (scan_line_ff == '0);
      info.last       = last_pix;
      info.glyph_line = glyph_line_ff;
      info.bit_sel    = scan_col_ff[3:1];

      cell_addr = blank ? '0
                        : CB_AW'(32'(text_row_ff) * COLS + 32'(scan_col_ff >> 4));
      row_index = blank ? '0 : RI_W'(text_row_ff);

      scan_col_in   = scan_col_ff;
      scan_line_in  = scan_line_ff;
      text_row_in   = text_row_ff;
      glyph_line_in = glyph_line_ff;
      if (step) begin
         if (last_pix) begin
            scan_col_in   = '0;
            scan_line_in  = '0;
            text_row_in   = '0;
            glyph_line_in = '0;
         end else if (last_col) begin
            scan_col_in  = '0;
            scan_line_in = SH_W'(next_line);
            if (line_done) begin
               glyph_line_in = glyph_line_ff + 1'b1;
               if (row_done) begin
                  glyph_line_in = '0;
                  if (32'(text_row_ff) < ROWS) begin
                     text_row_in = text_row_ff + 1'b1;
                  end
               end
            end
         end else begin
            scan_col_in = scan_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff   <= '0;
         scan_line_ff  <= '0;
         text_row_ff   <= '0;
         glyph_line_ff <= '0;
      end else begin
         scan_col_ff   <= scan_col_in;
         scan_line_ff  <= scan_line_in;
         text_row_ff   <= text_row_in;
         glyph_line_ff <= glyph_line_in;
      end
   end

endmodule

### sv/text_mode_display_controller.sv
// channel   | dir | handshake          | payload
// req_chan  | in  | valid/ready        | mode, char_code, pen_color, pos_x, pos_y,
//           |     |                    | font_address, font_byte
// rsp_chan  | out | valid/ready        | pixel_color, frame_start, frame_last
// csr_chan  | in  | valid/ready (1)    | data = background_color
//
// A pixel tick passes the char buffer read, the font store read and the output
// register in turn; one pixel per cycle unless a rsp_chan stall or a sweep holds it.
// Reset and every clear run a sweep of all COLS*ROWS (160 by default) entries
// of the character buffer, one entry per cycle, with req_chan.ready low.
// A stall on rsp_chan freezes the pixel pipeline and holds req_chan.ready low.
module text_mode_display_controller #(
   parameter int COLS          = tmdc_pkg::COLS_DEFAULT,
   parameter int ROWS          = tmdc_pkg::ROWS_DEFAULT,
   parameter int BOTTOM_LINE   = tmdc_pkg::BOTTOM_LINE_DEFAULT,
   parameter int SCREEN_WIDTH  = tmdc_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = tmdc_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   tmdc_req_if.sink   req_chan,
   tmdc_rsp_if.source rsp_chan,
   tmdc_csr_if.sink   csr_chan
);
   localparam int CB_DEPTH = COLS * ROWS;
   localparam int CB_AW    = tmdc_pkg::addr_width(CB_DEPTH);
   localparam int RI_W     = tmdc_pkg::addr_width(ROWS);
   localparam int CC_W     = $clog2(COLS + 1);
   localparam int CR_W     = $clog2(ROWS + 1);
   localparam int GLYPH_DEPTH = 1 << tmdc_pkg::FONT_ADDR_W;

   tmdc_pkg::ctl_state_type state_ff, state_in;
   logic [CB_AW-1:0] sweep_ff, sweep_in;

   logic [tmdc_pkg::CODE_W-1:0]  char_mem [CB_DEPTH];
   logic [tmdc_pkg::CODE_W-1:0]  glyph_mem [GLYPH_DEPTH];
   logic [tmdc_pkg::COLOR_W-1:0] row_color_ff [ROWS];
   logic [tmdc_pkg::COLOR_W-1:0] bg_color_ff;

   logic [CC_W-1:0] cursor_col_ff, cursor_col_in;
   logic [CR_W-1:0] cursor_row_ff, cursor_row_in;

   logic advance;
   logic req_ready;
   logic fire;
   tmdc_pkg::mode_type mode;
   logic [tmdc_pkg::CODE_W-1:0] hex_code;
   logic [tmdc_pkg::CODE_W-1:0] print_code;
   logic [CB_AW-1:0] cb_waddr;
   logic cb_we;
   logic color_we;
   logic glyph_we;
   logic pixel_go;
   logic clear_go;

   tmdc_pkg::scan_info_type scan_info;
   logic [CB_AW-1:0] cell_addr;
   logic [RI_W-1:0]  row_index;

   logic                          v1_ff, v2_ff, out_valid_ff;
   tmdc_pkg::scan_info_type       s1_info_ff, s2_info_ff;
   logic [tmdc_pkg::COLOR_W-1:0]  s1_color_ff, s2_color_ff;
   logic [tmdc_pkg::CODE_W-1:0]   cb_rd_ff;
   logic [tmdc_pkg::CODE_W-1:0]   glyph_rd_ff;
   logic [tmdc_pkg::COLOR_W-1:0]  out_color_ff, out_color_in;
   logic                          out_first_ff, out_last_ff;

   tmdc_scan #(
      .COLS          (COLS),
      .ROWS          (ROWS),
      .BOTTOM_LINE   (BOTTOM_LINE),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (pixel_go),
      .info      (scan_info),
      .cell_addr (cell_addr),
      .row_index (row_index)
   );

   assign advance          = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = req_ready;
   assign fire             = req_chan.valid && req_ready;
   assign mode             = tmdc_pkg::mode_type'(req_chan.mode);
   assign csr_chan.ready   = 1'b1;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_color = out_color_ff;
   assign rsp_chan.frame_start = out_first_ff;
   assign rsp_chan.frame_last  = out_last_ff;

   // sweep control
   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      req_ready = 1'b0;
      case (state_ff)
         tmdc_pkg::ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CB_AW'(CB_DEPTH - 1)) begin
               state_in = tmdc_pkg::ST_RUN;
            end
         end
         tmdc_pkg::ST_RUN: begin
            req_ready = advance;
            if (clear_go) begin
               state_in = tmdc_pkg::ST_SWEEP;
               sweep_in = '0;
            end
         end
         default: begin
            state_in = tmdc_pkg::ST_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmdc_pkg::ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // item decode
   always_comb begin
      hex_code = (req_chan.char_code[3:0] > tmdc_pkg::HEX_LAST_DIGIT)
               ? tmdc_pkg::HEX_ALPHA_BASE + {4'd0, req_chan.char_code[3:0]}
               : tmdc_pkg::HEX_DIGIT_BASE + {4'd0, req_chan.char_code[3:0]};
      print_code = (mode == tmdc_pkg::MODE_HEX) ? hex_code : req_chan.char_code;
      cb_waddr   = CB_AW'(32'(cursor_row_ff) * COLS + 32'(cursor_col_ff));

      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      cb_we    = 1'b0;
      color_we = 1'b0;
      glyph_we = 1'b0;
      pixel_go = 1'b0;
      clear_go = 1'b0;
      if (fire) begin
         case (mode)
            tmdc_pkg::MODE_PRINT, tmdc_pkg::MODE_HEX: begin
               if (print_code == tmdc_pkg::CHAR_CR) begin
                  cursor_col_in = '0;
               end else if (print_code == tmdc_pkg::CHAR_LF) begin
                  if (32'(cursor_row_ff) < ROWS) begin
                     cursor_row_in = cursor_row_ff + 1'b1;
                  end
               end else if ((32'(cursor_col_ff) < COLS) && (32'(cursor_row_ff) < ROWS)) begin
                  cb_we         = 1'b1;
                  color_we      = print_code > tmdc_pkg::CHAR_SPACE;
                  cursor_col_in = cursor_col_ff + 1'b1;
               end
            end
            tmdc_pkg::MODE_POSITION: begin
               if (req_chan.pos_x[7]) begin
                  cursor_col_in = '0;
               end else if (int'(req_chan.pos_x) > COLS) begin
                  cursor_col_in = CC_W'(COLS);
               end else begin
                  cursor_col_in = CC_W'(req_chan.pos_x);
               end
               if (req_chan.pos_y[7]) begin
                  cursor_row_in = '0;
               end else if (int'(req_chan.pos_y) > ROWS) begin
                  cursor_row_in = CR_W'(ROWS);
               end else begin
                  cursor_row_in = CR_W'(req_chan.pos_y);
               end
            end
            tmdc_pkg::MODE_CLEAR: begin
               clear_go      = 1'b1;
               cursor_col_in = '0;
               cursor_row_in = '0;
            end
            tmdc_pkg::MODE_FONT: begin
               glyph_we = 1'b1;
            end
            tmdc_pkg::MODE_PIXEL: begin
               pixel_go = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         bg_color_ff   <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         if (csr_chan.valid) begin
            bg_color_ff <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         for (int i = 0; i < ROWS; i++) begin
            row_color_ff[i] <= tmdc_pkg::COLOR_WHITE;
         end
      end else if (color_we) begin
         row_color_ff[RI_W'(cursor_row_ff)] <= req_chan.pen_color;
      end
   end

   // character buffer: one write port (sweep or print), one read for the scan
   always_ff @(posedge clock) begin
      if (state_ff == tmdc_pkg::ST_SWEEP) begin
         char_mem[sweep_ff] <= tmdc_pkg::CHAR_SPACE;
      end else if (cb_we) begin
         char_mem[cb_waddr] <= print_code;
      end
      if (pixel_go) begin
         cb_rd_ff <= char_mem[cell_addr];
      end
   end

   // font store, read-first so a load never shows up in an older pixel
   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[req_chan.font_address] <= req_chan.font_byte;
      end
      if (advance && v1_ff) begin
         glyph_rd_ff <= glyph_mem[{s1_info_ff.glyph_line, cb_rd_ff}];
      end
   end

   // pixel pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pixel_go;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_comb begin
      out_color_in = (!s2_info_ff.blank && glyph_rd_ff[~s2_info_ff.bit_sel])
                   ? s2_color_ff : bg_color_ff;
   end

   always_ff @(posedge clock) begin
      if (pixel_go) begin
         s1_info_ff  <= scan_info;
         s1_color_ff <= row_color_ff[row_index];
      end
      if (advance) begin
         s2_info_ff   <= s1_info_ff;
         s2_color_ff  <= s1_color_ff;
         out_color_ff <= out_color_in;
         out_first_ff <= s2_info_ff.first;
         out_last_ff  <= s2_info_ff.last;
      end
   end

endmodule

### sv/tmdc_checker.sv
`include "text_mode_display_controller_assert.svh"

module tmdc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tmdc_pkg::COLOR_W-1:0] pixel_color,
   input logic                         frame_start,
   input logic                         frame_last
);

   // the buffer sweep after reset keeps the input closed
   `TMDC_ASSERT_ALWAYS_NEXT(a_req_closed_after_reset, clock, reset, !req_ready)

   `TMDC_ASSERT_ALWAYS_NEXT(a_no_rsp_after_reset, clock, reset, !rsp_valid)

   // a blocked result freezes the pipeline, so nothing new comes in
   `TMDC_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   `TMDC_ASSERT_NOW(a_start_not_last, clock, reset, rsp_valid && frame_start, !frame_last)

   `TMDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_color) && $stable(frame_start) && $stable(frame_last))

endmodule

bind text_mode_display_controller tmdc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .pixel_color (rsp_chan.pixel_color),
   .frame_start (rsp_chan.frame_start),
   .frame_last  (rsp_chan.frame_last)
);
